[hw/rtl/lqr_balance_torque_controller_unit_assert.svh]
// Assertion macros for the balance torque controller.
// Used by the RTL files that carry concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef LQR_BALANCE_TORQUE_CONTROLLER_UNIT_ASSERT_SVH
`define LQR_BALANCE_TORQUE_CONTROLLER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset only.
`define LQR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define LQR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LQR_ASSERT(lbl, prop, msg)
`define LQR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/lqr_bal_pkg.sv]
// Package for the balance torque controller: widths, codes, types and helpers.
// No dependencies; imported by every other RTL file of the block.
`default_nettype none

package lqr_bal_pkg;

  // Motor polarity, each one of -1, 0 or +1.
  localparam int LEFT_MOTOR_SIGN  = 1;
  localparam int RIGHT_MOTOR_SIGN = 1;

  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 32;
  localparam int SUM_W     = 34;   // signed sum of two wheel readings
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 33;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 51;   // product shifted by 16, and the force sum
  localparam int TILT_W    = 33;
  localparam int TILT_Q_W  = 19;   // tilt within the fall angle

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH_OFFSET,
    REG_FALL_ANGLE,
    REG_TORQUE_LIMIT,
    REG_WHEEL_RADIUS,
    REG_GAIN_PITCH,
    REG_GAIN_PITCH_RATE,
    REG_GAIN_POSITION,
    REG_GAIN_VELOCITY
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_UPDATE,
    KIND_ENABLE,
    KIND_DISABLE
  } kind_e;

  typedef struct packed {
    logic signed [18:0] pitch_offset;
    logic        [17:0] fall_angle;
    logic        [30:0] torque_limit;
    logic        [30:0] wheel_radius;
    logic signed [31:0] gain_pitch;
    logic signed [31:0] gain_pitch_rate;
    logic signed [31:0] gain_position;
    logic signed [31:0] gain_velocity;
  } cfg_t;

  typedef struct packed {
    logic               fault;
    logic               active;
    logic               rejected;
    logic signed [31:0] left_torque;
    logic signed [31:0] right_torque;
    logic signed [31:0] wheel_travel;
    logic signed [31:0] wheel_speed;
    logic signed [31:0] force_command;
  } out_t;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sign_term(input int sgn,
                                                        input logic signed [31:0] v);
    logic signed [SUM_W-1:0] ext;
    ext = SUM_W'(v);
    if (sgn > 0) begin
      return ext;
    end else if (sgn < 0) begin
      return -ext;
    end
    return '0;
  endfunction

  function automatic logic signed [SUM_W-1:0] wheel_sum(input logic signed [31:0] l,
                                                        input logic signed [31:0] r);
    return sign_term(LEFT_MOTOR_SIGN, l) + sign_term(RIGHT_MOTOR_SIGN, r);
  endfunction

  // The torque lies within the limit, so its negation always fits.
  function automatic logic signed [31:0] apply_sign(input int sgn,
                                                    input logic signed [31:0] v);
    if (sgn > 0) begin
      return v;
    end else if (sgn < 0) begin
      return -v;
    end
    return '0;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lqr_bal_if.sv]
// Channel interfaces of the balance torque controller: sample input, result output
// and configuration write. Depends on lqr_bal_pkg.
`default_nettype none

interface lqr_bal_in_if;
  import lqr_bal_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               sample_valid;
  logic signed [31:0] pitch_angle;
  logic signed [31:0] pitch_rate;
  logic signed [31:0] left_angle;
  logic signed [31:0] right_angle;
  logic signed [31:0] left_speed;
  logic signed [31:0] right_speed;

  modport source (output valid, kind, sample_valid, pitch_angle, pitch_rate, left_angle,
                  right_angle, left_speed, right_speed, input ready);
  modport sink (input valid, kind, sample_valid, pitch_angle, pitch_rate, left_angle,
                right_angle, left_speed, right_speed, output ready);
endinterface

interface lqr_bal_out_if;
  import lqr_bal_pkg::*;
  logic               valid;
  logic               ready;
  logic               fault;
  logic               active;
  logic               rejected;
  logic signed [31:0] left_torque;
  logic signed [31:0] right_torque;
  logic signed [31:0] wheel_travel;
  logic signed [31:0] wheel_speed;
  logic signed [31:0] force_command;

  modport source (output valid, fault, active, rejected, left_torque, right_torque,
                  wheel_travel, wheel_speed, force_command, input ready);
  modport sink (input valid, fault, active, rejected, left_torque, right_torque,
                wheel_travel, wheel_speed, force_command, output ready);
endinterface

interface lqr_bal_cfg_if;
  import lqr_bal_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/lqr_bal_cfg.sv]
// Configuration register file of the balance torque controller.
// Depends on lqr_bal_pkg and the lqr_bal_cfg_if interface.
`default_nettype none

module lqr_bal_cfg (
  input  wire                clk_i,
  input  wire                rst_ni,
  lqr_bal_cfg_if.sink        cfg_i,
  output lqr_bal_pkg::cfg_t  cfg_o
);
  import lqr_bal_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken; ready is held high.
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_offset    <= '0;
      cfg_q.fall_angle      <= 18'd32768;
      cfg_q.torque_limit    <= 31'd65536;
      cfg_q.wheel_radius    <= 31'd3277;
      cfg_q.gain_pitch      <= '0;
      cfg_q.gain_pitch_rate <= '0;
      cfg_q.gain_position   <= '0;
      cfg_q.gain_velocity   <= '0;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_PITCH_OFFSET:    cfg_q.pitch_offset    <= $signed(cfg_i.data[18:0]);
        REG_FALL_ANGLE:      cfg_q.fall_angle      <= cfg_i.data[17:0];
        REG_TORQUE_LIMIT:    cfg_q.torque_limit    <= cfg_i.data[30:0];
        REG_WHEEL_RADIUS:    cfg_q.wheel_radius    <= cfg_i.data[30:0];
        REG_GAIN_PITCH:      cfg_q.gain_pitch      <= $signed(cfg_i.data);
        REG_GAIN_PITCH_RATE: cfg_q.gain_pitch_rate <= $signed(cfg_i.data);
        REG_GAIN_POSITION:   cfg_q.gain_position   <= $signed(cfg_i.data);
        REG_GAIN_VELOCITY:   cfg_q.gain_velocity   <= $signed(cfg_i.data);
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lqr_bal_mul.sv]
// Shared signed multiplier of the balance torque controller, product registered.
// Depends on lqr_bal_pkg for the operand widths.
`default_nettype none

module lqr_bal_mul (
  input  wire                                          clk_i,
  input  wire logic signed [lqr_bal_pkg::MUL_A_W-1:0]  a_i,
  input  wire logic signed [lqr_bal_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [lqr_bal_pkg::PROD_W-1:0]        prod_o
);
  import lqr_bal_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

endmodule

`default_nettype wire

[hw/rtl/lqr_balance_torque_controller_unit.sv]
// Balance torque controller: sequencer around one shared multiplier.
// Usage:
//   in_i carries one event per transaction: an update, an enable that captures the
//   travel origin, or a disable, each with one sensor sample. out_o returns exactly
//   one result transaction per input transaction, in order. cfg_i writes one of the
//   eight configuration registers per transaction; write it only while
//   no item is in progress.
//   An update passes seven products through the single multiplier one after another,
//   each registered before use; an enable captures the origin in a state of its own.
//   No new item is accepted until the current one has finished. The result is offered in
//   the same cycle as the block becomes ready again.
//   The result sits in an output register. A new item is accepted while that result
//   waits; the sequencer then holds its finished result until the receiver has taken
//   the previous one, so a stalled receiver stalls the input after one item.
//   Reset clears the armed flag and the travel origin, loads the register defaults and
//   empties the output register.
// Depends on lqr_bal_pkg, lqr_bal_if, lqr_bal_cfg, lqr_bal_mul and the assert header.
`default_nettype none
`include "lqr_balance_torque_controller_unit_assert.svh"

module lqr_balance_torque_controller_unit (
  input  wire           clk_i,
  input  wire           rst_ni,
  lqr_bal_in_if.sink    in_i,
  lqr_bal_out_if.source out_o,
  lqr_bal_cfg_if.sink   cfg_i
);
  import lqr_bal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ENPOS,
    S_UPOS,
    S_USPD,
    S_UG0,
    S_UG1,
    S_UG2,
    S_UG3,
    S_UTQ,
    S_UCLAMP,
    S_FINISH
  } state_e;

  cfg_t                       cfg;
  state_e                     state_q;
  logic                       armed_q;
  logic signed [31:0]         origin_q;
  logic [1:0]                 kind_q;
  logic                       svalid_q;
  logic signed [31:0]         pitch_q;
  logic signed [31:0]         rate_q;
  logic signed [SUM_W-1:0]    pos_sum_q;
  logic signed [SUM_W-1:0]    spd_sum_q;
  logic signed [TILT_Q_W-1:0] tilt_q;
  logic signed [31:0]         travel_q;
  logic signed [31:0]         speed_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [31:0]         force_q;
  out_t                       res_q;
  out_t                       out_q;
  logic                       out_valid_q;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [MUL_B_W-1:0]  radius_op;
  logic signed [TILT_W-1:0]   tilt;
  logic [TILT_W-1:0]          tilt_mag;
  logic                       fall;
  logic signed [ACC_W-1:0]    prod_sh16;
  logic signed [ACC_W-1:0]    prod_sh17;
  logic signed [31:0]         wheel_sat;
  logic signed [31:0]         travel_sat;
  logic signed [31:0]         force_sat;
  logic signed [ACC_W-1:0]    limit;
  logic signed [31:0]         torque;

  lqr_bal_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lqr_bal_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign radius_op = $signed({2'b00, cfg.wheel_radius});

  // Operand selection: the product issued in one state is used in the next.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DECODE: begin
        mul_a = pos_sum_q;
        mul_b = radius_op;
      end
      S_UPOS: begin
        mul_a = spd_sum_q;
        mul_b = radius_op;
      end
      S_USPD: begin
        mul_a = MUL_A_W'(tilt_q);
        mul_b = MUL_B_W'(cfg.gain_pitch);
      end
      S_UG0: begin
        mul_a = MUL_A_W'(rate_q);
        mul_b = MUL_B_W'(cfg.gain_pitch_rate);
      end
      S_UG1: begin
        mul_a = MUL_A_W'(travel_q);
        mul_b = MUL_B_W'(cfg.gain_position);
      end
      S_UG2: begin
        mul_a = MUL_A_W'(speed_q);
        mul_b = MUL_B_W'(cfg.gain_velocity);
      end
      S_UTQ: begin
        mul_a = MUL_A_W'(force_q);
        mul_b = radius_op;
      end
      default: begin
      end
    endcase
  end

  // Tilt check and the shifts of the registered product round toward minus infinity.
  always_comb begin
    tilt      = TILT_W'(pitch_q) - TILT_W'(cfg.pitch_offset);
    tilt_mag  = tilt[TILT_W-1] ? $unsigned(-tilt) : $unsigned(tilt);
    fall      = tilt_mag > TILT_W'(cfg.fall_angle);
    prod_sh16 = $signed(prod[PROD_W-1:16]);
    prod_sh17 = ACC_W'($signed(prod[PROD_W-1:17]));
    wheel_sat = sat32(prod_sh17);
    travel_sat = sat32(ACC_W'(wheel_sat) - ACC_W'(origin_q));
    force_sat = sat32(-(acc_q + prod_sh16));
    limit     = ACC_W'($signed({1'b0, cfg.torque_limit}));
    if (prod_sh17 > limit) begin
      torque = limit[31:0];
    end else if (prod_sh17 < -limit) begin
      torque = 32'(-limit);
    end else begin
      torque = prod_sh17[31:0];
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.fault         = out_q.fault;
  assign out_o.active        = out_q.active;
  assign out_o.rejected      = out_q.rejected;
  assign out_o.left_torque   = out_q.left_torque;
  assign out_o.right_torque  = out_q.right_torque;
  assign out_o.wheel_travel  = out_q.wheel_travel;
  assign out_o.wheel_speed   = out_q.wheel_speed;
  assign out_o.force_command = out_q.force_command;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      armed_q     <= 1'b0;
      origin_q    <= '0;
      kind_q      <= '0;
      svalid_q    <= 1'b0;
      pitch_q     <= '0;
      rate_q      <= '0;
      pos_sum_q   <= '0;
      spd_sum_q   <= '0;
      tilt_q      <= '0;
      travel_q    <= '0;
      speed_q     <= '0;
      acc_q       <= '0;
      force_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The finishing state reloads the output register itself.
      if (out_valid_q && out_o.ready && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            kind_q    <= in_i.kind;
            svalid_q  <= in_i.sample_valid;
            pitch_q   <= in_i.pitch_angle;
            rate_q    <= in_i.pitch_rate;
            pos_sum_q <= wheel_sum(in_i.left_angle, in_i.right_angle);
            spd_sum_q <= wheel_sum(in_i.left_speed, in_i.right_speed);
            res_q     <= '0;
            state_q   <= S_DECODE;
          end
        end
        S_DECODE: begin
          tilt_q  <= tilt[TILT_Q_W-1:0];
          state_q <= S_FINISH;
          case (kind_q)
            KIND_ENABLE: begin
              if (!svalid_q) begin
                res_q.rejected <= 1'b1;
              end else begin
                state_q <= S_ENPOS;
              end
            end
            KIND_DISABLE: begin
              armed_q <= 1'b0;
            end
            KIND_UPDATE: begin
              if (!svalid_q) begin
                res_q.fault <= 1'b1;
              end else if (armed_q) begin
                if (fall) begin
                  armed_q     <= 1'b0;
                  res_q.fault <= 1'b1;
                end else begin
                  state_q <= S_UPOS;
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_ENPOS: begin
          origin_q     <= wheel_sat;
          armed_q      <= 1'b1;
          res_q.active <= 1'b1;
          state_q      <= S_FINISH;
        end
        S_UPOS: begin
          travel_q <= travel_sat;
          state_q  <= S_USPD;
        end
        S_USPD: begin
          speed_q <= wheel_sat;
          state_q <= S_UG0;
        end
        S_UG0: begin
          acc_q   <= prod_sh16;
          state_q <= S_UG1;
        end
        S_UG1: begin
          acc_q   <= acc_q + prod_sh16;
          state_q <= S_UG2;
        end
        S_UG2: begin
          acc_q   <= acc_q + prod_sh16;
          state_q <= S_UG3;
        end
        S_UG3: begin
          force_q <= force_sat;
          state_q <= S_UTQ;
        end
        S_UTQ: begin
          state_q <= S_UCLAMP;
        end
        S_UCLAMP: begin
          res_q.active        <= 1'b1;
          res_q.left_torque   <= apply_sign(LEFT_MOTOR_SIGN, torque);
          res_q.right_torque  <= apply_sign(RIGHT_MOTOR_SIGN, torque);
          res_q.wheel_travel  <= travel_q;
          res_q.wheel_speed   <= speed_q;
          res_q.force_command <= force_q;
          state_q             <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `LQR_ASSERT(a_busy_after_accept, (in_i.valid && in_i.ready) |=> !in_i.ready, "input accepted while busy")
  `LQR_ASSERT(a_flags_exclusive, out_o.valid |-> $onehot0({out_o.fault, out_o.active, out_o.rejected}), "more than one status flag set")
  `LQR_ASSERT(a_zero_when_inactive, (out_o.valid && !out_o.active) |-> (out_o.left_torque == 0 && out_o.right_torque == 0 && out_o.wheel_travel == 0 && out_o.wheel_speed == 0 && out_o.force_command == 0), "nonzero payload on inactive result")
  `LQR_ASSERT(a_disable_disarms, (state_q == S_DECODE && kind_q == KIND_DISABLE) |=> !armed_q, "disable left the controller armed")
  `LQR_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_o.valid, "result offered during reset")

endmodule

`default_nettype wire

[sim/lqr_bal_checker.sv]
`timescale 1ns / 1ps
// Result checker for the balance torque controller: watches the sample, result and
// register write channels, predicts every result and compares it. Needs lqr_bal_pkg, lqr_bal_if.
module lqr_bal_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  lqr_bal_in_if  in_mon,
  lqr_bal_out_if out_mon,
  lqr_bal_cfg_if cfg_mon,
  output int     fail_count_o,
  output int     pending_o,
  output int     checked_o
);
  import lqr_bal_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  cfg_t               regs_q;
  logic               armed_q;
  logic signed [31:0] origin_q;
  out_t               awaited_results[$];

  function automatic longint sat_word(input longint v);
    if (v > WORD_MAX) begin
      return WORD_MAX;
    end else if (v < WORD_MIN) begin
      return WORD_MIN;
    end
    return v;
  endfunction

  // Half the radius times the signed sum of the two wheel readings.
  function automatic longint wheel_distance(input longint a, input longint b);
    longint sum;
    sum = longint'(LEFT_MOTOR_SIGN) * a + longint'(RIGHT_MOTOR_SIGN) * b;
    return sat_word((sum * longint'(regs_q.wheel_radius)) >>> 17);
  endfunction

  function automatic out_t balance_result(input logic [1:0] kind, input logic sample_ok,
                                          input logic signed [31:0] pitch,
                                          input logic signed [31:0] rate,
                                          input logic signed [31:0] la,
                                          input logic signed [31:0] ra,
                                          input logic signed [31:0] ls,
                                          input logic signed [31:0] rs);
    out_t   r;
    longint tilt;
    longint mag;
    longint travel;
    longint speed;
    longint force_sum;
    longint torque;
    longint limit;
    r = '0;
    case (kind)
      KIND_ENABLE: begin
        if (!sample_ok) begin
          r.rejected = 1'b1;
        end else begin
          origin_q = 32'(wheel_distance(longint'(la), longint'(ra)));
          armed_q  = 1'b1;
          r.active = 1'b1;
        end
      end
      KIND_DISABLE: begin
        armed_q = 1'b0;
      end
      KIND_UPDATE: begin
        if (!sample_ok) begin
          r.fault = 1'b1;
        end else if (armed_q) begin
          tilt = longint'(pitch) - longint'($signed(regs_q.pitch_offset));
          mag  = (tilt < 0) ? -tilt : tilt;
          if (mag > longint'(regs_q.fall_angle)) begin
            armed_q = 1'b0;
            r.fault = 1'b1;
          end else begin
            travel = sat_word(wheel_distance(longint'(la), longint'(ra)) - longint'(origin_q));
            speed  = wheel_distance(longint'(ls), longint'(rs));
            force_sum = ((longint'($signed(regs_q.gain_pitch)) * tilt) >>> 16)
                      + ((longint'($signed(regs_q.gain_pitch_rate)) * longint'(rate)) >>> 16)
                      + ((longint'($signed(regs_q.gain_position)) * travel) >>> 16)
                      + ((longint'($signed(regs_q.gain_velocity)) * speed) >>> 16);
            force_sum = sat_word(-force_sum);
            torque = (force_sum * longint'(regs_q.wheel_radius)) >>> 17;
            limit  = longint'(regs_q.torque_limit);
            if (torque > limit) begin
              torque = limit;
            end
            if (torque < -limit) begin
              torque = -limit;
            end
            r.active        = 1'b1;
            r.left_torque   = 32'(longint'(LEFT_MOTOR_SIGN) * torque);
            r.right_torque  = 32'(longint'(RIGHT_MOTOR_SIGN) * torque);
            r.wheel_travel  = 32'(travel);
            r.wheel_speed   = 32'(speed);
            r.force_command = 32'(force_sum);
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_failure(input string msg);
    $display("checker: %s", msg);
    fail_count_o++;
  endtask

  task automatic compare_result(input out_t got, input out_t want);
    string tag;
    tag = $sformatf("result %0d", checked_o);
    if (got.fault !== want.fault) begin
      report_failure($sformatf("%s fault %b, expected %b", tag, got.fault, want.fault));
    end
    if (got.active !== want.active) begin
      report_failure($sformatf("%s active %b, expected %b", tag, got.active, want.active));
    end
    if (got.rejected !== want.rejected) begin
      report_failure($sformatf("%s rejected %b, expected %b", tag, got.rejected,
                               want.rejected));
    end
    if (got.left_torque !== want.left_torque) begin
      report_failure($sformatf("%s left_torque %h, expected %h", tag, got.left_torque,
                               want.left_torque));
    end
    if (got.right_torque !== want.right_torque) begin
      report_failure($sformatf("%s right_torque %h, expected %h", tag, got.right_torque,
                               want.right_torque));
    end
    if (got.wheel_travel !== want.wheel_travel) begin
      report_failure($sformatf("%s wheel_travel %h, expected %h", tag, got.wheel_travel,
                               want.wheel_travel));
    end
    if (got.wheel_speed !== want.wheel_speed) begin
      report_failure($sformatf("%s wheel_speed %h, expected %h", tag, got.wheel_speed,
                               want.wheel_speed));
    end
    if (got.force_command !== want.force_command) begin
      report_failure($sformatf("%s force_command %h, expected %h", tag, got.force_command,
                               want.force_command));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t got;
    if (!rst_ni) begin
      regs_q.pitch_offset    = '0;
      regs_q.fall_angle      = 18'd32768;
      regs_q.torque_limit    = 31'd65536;
      regs_q.wheel_radius    = 31'd3277;
      regs_q.gain_pitch      = '0;
      regs_q.gain_pitch_rate = '0;
      regs_q.gain_position   = '0;
      regs_q.gain_velocity   = '0;
      armed_q                = 1'b0;
      origin_q               = '0;
      awaited_results.delete();
      fail_count_o           = 0;
      checked_o              = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_PITCH_OFFSET:    regs_q.pitch_offset    = cfg_mon.data[18:0];
          REG_FALL_ANGLE:      regs_q.fall_angle      = cfg_mon.data[17:0];
          REG_TORQUE_LIMIT:    regs_q.torque_limit    = cfg_mon.data[30:0];
          REG_WHEEL_RADIUS:    regs_q.wheel_radius    = cfg_mon.data[30:0];
          REG_GAIN_PITCH:      regs_q.gain_pitch      = cfg_mon.data;
          REG_GAIN_PITCH_RATE: regs_q.gain_pitch_rate = cfg_mon.data;
          REG_GAIN_POSITION:   regs_q.gain_position   = cfg_mon.data;
          REG_GAIN_VELOCITY:   regs_q.gain_velocity   = cfg_mon.data;
          default: begin
          end
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_results.push_back(balance_result(in_mon.kind, in_mon.sample_valid,
                                                 in_mon.pitch_angle, in_mon.pitch_rate,
                                                 in_mon.left_angle, in_mon.right_angle,
                                                 in_mon.left_speed, in_mon.right_speed));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.fault         = out_mon.fault;
        got.active        = out_mon.active;
        got.rejected      = out_mon.rejected;
        got.left_torque   = out_mon.left_torque;
        got.right_torque  = out_mon.right_torque;
        got.wheel_travel  = out_mon.wheel_travel;
        got.wheel_speed   = out_mon.wheel_speed;
        got.force_command = out_mon.force_command;
        if (awaited_results.size() == 0) begin
          report_failure("result transaction with no result outstanding");
        end else begin
          compare_result(got, awaited_results.pop_front());
          checked_o++;
        end
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Top level of the balance torque controller testbench: clock, reset, stimulus and verdict.
// Needs lqr_bal_pkg, lqr_bal_if, the controller RTL and lqr_bal_checker.
module testbench;
  import lqr_bal_pkg::*;

  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 24;
  localparam int         PHASE_EVENTS = 155;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  logic clk_i;
  logic rst_ni;

  lqr_bal_in_if  in_if ();
  lqr_bal_out_if out_if ();
  lqr_bal_cfg_if cfg_if ();

  int     fail_count;
  int     pending;
  int     checked;
  int     idle_pct;
  int     events_sent;
  int     settings_done;
  int     stall_cycles = 0;
  longint cur_offset;
  longint cur_fall;

  lqr_balance_torque_controller_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  lqr_bal_checker result_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_mon     (cfg_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Ends the run if the block stops moving transactions altogether.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      1: return 32'(int'($urandom_range(0, 262144)) - 131072);
      2: return 32'(int'($urandom_range(0, 33554432)) - 16777216);
      3: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Mostly within the fall angle of the offset so that updates get past the tilt check.
  function automatic logic [31:0] pick_pitch();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'(cur_offset + cur_fall);
      2: return 32'(cur_offset - cur_fall);
      3: return 32'(cur_offset + cur_fall + 1);
      4: return 32'(cur_offset - cur_fall - 1);
      default: return 32'(cur_offset + longint'($urandom_range(0, 32'(2 * cur_fall))) - cur_fall);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    return 32'(int'($urandom_range(0, 1048576)) - 524288);
  endfunction

  // Leaves valid high on return, so a following event goes out without a gap.
  task automatic send_event(input logic [1:0] kind, input logic sample_ok,
                            input logic [31:0] pa, input logic [31:0] pr,
                            input logic [31:0] la, input logic [31:0] ra,
                            input logic [31:0] ls, input logic [31:0] rs);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= kind;
    in_if.sample_valid <= sample_ok;
    in_if.pitch_angle  <= pa;
    in_if.pitch_rate   <= pr;
    in_if.left_angle   <= la;
    in_if.right_angle  <= ra;
    in_if.left_speed   <= ls;
    in_if.right_speed  <= rs;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    if (kind != KIND_UNUSED) begin
      events_sent++;
    end
  endtask

  task automatic send_random(input logic [1:0] kind, input logic sample_ok);
    send_event(kind, sample_ok, pick_pitch(), pick_word(), pick_word(), pick_word(),
               pick_word(), pick_word());
  endtask

  // Waits until every result is back and the block will take a new event.
  task automatic quiesce();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || !in_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) begin
      @(posedge clk_i);
    end
    if (idx == REG_PITCH_OFFSET) begin
      cur_offset = longint'($signed(value[18:0]));
    end
    if (idx == REG_FALL_ANGLE) begin
      cur_fall = longint'(value[17:0]);
    end
  endtask

  task automatic program_registers(input logic [31:0] offset, input logic [31:0] fall,
                                   input logic [31:0] limit, input logic [31:0] radius,
                                   input logic [31:0] g_pitch, input logic [31:0] g_rate,
                                   input logic [31:0] g_pos, input logic [31:0] g_vel);
    quiesce();
    write_register(REG_PITCH_OFFSET, offset);
    write_register(REG_FALL_ANGLE, fall);
    write_register(REG_TORQUE_LIMIT, limit);
    write_register(REG_WHEEL_RADIUS, radius);
    write_register(REG_GAIN_PITCH, g_pitch);
    write_register(REG_GAIN_PITCH_RATE, g_rate);
    write_register(REG_GAIN_POSITION, g_pos);
    write_register(REG_GAIN_VELOCITY, g_vel);
    cfg_if.valid <= 1'b0;
    settings_done++;
  endtask

  // Mostly arm, run a burst of updates, sometimes disarm; the rest is loose noise.
  task automatic run_random(input int quota);
    int first;
    int burst;
    first = events_sent;
    while (events_sent - first < quota) begin
      if ($urandom_range(99) < 10) begin
        send_random(2'($urandom_range(3)), $urandom_range(9) != 0);
      end else begin
        send_random(KIND_ENABLE, $urandom_range(19) != 0);
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          send_random(KIND_UPDATE, $urandom_range(19) != 0);
        end
        if ($urandom_range(1) == 1) begin
          send_random(KIND_DISABLE, $urandom_range(1) == 1);
        end
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_UPDATE;
    in_if.sample_valid = 1'b0;
    in_if.pitch_angle  = '0;
    in_if.pitch_rate   = '0;
    in_if.left_angle   = '0;
    in_if.right_angle  = '0;
    in_if.left_speed   = '0;
    in_if.right_speed  = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_PITCH_OFFSET;
    cfg_if.data        = '0;
    idle_pct           = 11;
    events_sent        = 0;
    settings_done      = 0;
    cur_offset         = 0;
    cur_fall           = 32768;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: disarmed, invalid samples, unused kind, tilt at and past the limit.
    send_event(KIND_UPDATE, 1'b1, 32'h0000_1000, 32'h0001_0000, 32'h0002_0000,
               32'h0003_0000, 32'h0000_8000, 32'hFFFF_8000);
    send_event(KIND_UPDATE, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_event(KIND_ENABLE, 1'b0, 32'h0, 32'h0, 32'h1234_0000, 32'h0, 32'h0, 32'h0);
    send_event(KIND_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(KIND_DISABLE, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_event(KIND_ENABLE, 1'b1, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_event(KIND_UPDATE, 1'b1, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_event(KIND_UPDATE, 1'b1, 32'hFFFF_8000, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
    send_event(KIND_UPDATE, 1'b1, 32'h0000_8001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_event(KIND_UPDATE, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

    // Extreme gains and scaling: saturated travel, speed and force, torque on the clamp.
    program_registers(32'hFFFC_0000, 32'h0003_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_event(KIND_ENABLE, 1'b1, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_event(KIND_UPDATE, 1'b1, 32'hFFFC_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_event(KIND_UPDATE, 1'b1, 32'hFFF8_0001, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_event(KIND_UPDATE, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_event(KIND_ENABLE, 1'b1, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0);
    send_event(KIND_DISABLE, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_event(KIND_UPDATE, 1'b1, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

    program_registers(32'(int'($urandom_range(0, 40000)) - 20000), 32'd32768,
                      32'h0002_0000, 32'd3277, pick_gain(), pick_gain(), pick_gain(),
                      pick_gain());
    run_random(PHASE_EVENTS);

    // All registers at their largest values, with no idling on either side.
    idle_pct = 0;
    program_registers(32'h0003_FFFF, 32'h0003_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_random(PHASE_EVENTS);
    idle_pct = 11;

    // Smallest values: any nonzero tilt falls, and zero radius and limit null the torque.
    program_registers(32'hFFFC_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000);
    run_random(PHASE_EVENTS);

    repeat (2) begin
      program_registers($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom());
      run_random(PHASE_EVENTS);
    end

    program_registers(32'(-205887), 32'd205887, 32'd1, 32'h0001_0000, pick_gain(),
                      pick_gain(), pick_gain(), pick_gain());
    run_random(PHASE_EVENTS);

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d events over %0d register settings plus the reset values,",
             events_sent, settings_done);
    $display("summary: %0d results compared field by field", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
